@@ design/pressure_temperature_compensation_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the pressure and temperature compensation block
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset.
`define PTC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("ptc: assertion failed");
// Next-cycle implication, checked on every rising edge out of reset.
`define PTC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("ptc: assertion failed");
`else
`define PTC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define PTC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

@@ design/ptc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Compensation package
// Field widths, register codes, coefficient and pipeline control types.
// ---------------------------------------------------------------------------
package ptc_pkg;

  localparam int RAW_W     = 24;
  localparam int PRESS_W   = 30;
  localparam int TEMP_W    = 27;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;

  // Raw codes are scaled by two to the minus this.
  localparam int SCALE_SHIFT   = 19;
  localparam int MILLI_PER_DEG = 1000;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_A      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_B      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_C      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_LOADED = 2'd3;

  // Number of register stages from input to output register.
  localparam int STAGES = 9;

  typedef struct packed {
    logic               loaded;
    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [19:0] c00;
    logic signed [19:0] c10;
    logic signed [15:0] c01;
    logic signed [15:0] c11;
    logic signed [15:0] c20;
    logic signed [15:0] c21;
    logic signed [15:0] c30;
  } ptc_coef_t;

  typedef struct packed {
    logic [STAGES-1:0] en;
    logic [STAGES-1:0] vld;
  } ptc_ctrl_t;

endpackage

@@ design/ptc_in_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Raw sample channel
// Valid/ready channel carrying one raw pressure and temperature code pair.
// ---------------------------------------------------------------------------
interface ptc_in_if;
  import ptc_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure_code;
  logic [RAW_W-1:0] raw_temperature_code;

  modport source (output valid, output raw_pressure_code, output raw_temperature_code,
                  input ready);
  modport sink (input valid, input raw_pressure_code, input raw_temperature_code,
                output ready);
endinterface

@@ design/ptc_out_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Compensated result channel
// Valid/ready channel carrying status, pressure and temperature.
// ---------------------------------------------------------------------------
interface ptc_out_if;
  import ptc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      status;
  logic signed [PRESS_W-1:0] pressure_pascal;
  logic signed [TEMP_W-1:0]  temperature_millidegree;

  modport source (output valid, output status, output pressure_pascal,
                  output temperature_millidegree, input ready);
  modport sink (input valid, input status, input pressure_pascal,
                input temperature_millidegree, output ready);
endinterface

@@ design/ptc_cfg_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface ptc_cfg_if;
  import ptc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/pressure_temperature_compensation.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pressure and temperature compensation
// Turns raw barometric sensor code pairs into pascals and millidegrees.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch takes one item per handshake: a raw pressure code and a raw
//   temperature code, both 24-bit two's complement. out_ch returns one item
//   for each input item, in order: a status bit, the pressure in pascals and
//   the temperature in millidegrees, both truncated toward zero.
//   cfg_ch writes the three calibration words and the loaded flag; it is
//   always ready and should be used only while no item is in flight.
//   Throughput is one item per clock cycle while the receiver does not stall.
//   The datapath is nine register stages deep, set by the nested multiply
//   chain of the pressure polynomial; an accepted item enters the first
//   stage and advances stage by stage to the output register.
//   While out_ch is stalled the pipeline keeps filling its empty stages, so
//   in_ch stays ready until every stage holds an item; nothing is lost or
//   repeated. A synchronous reset on rst_n empties the pipeline and clears
//   the calibration registers, so items then report calibration not loaded.
// ---------------------------------------------------------------------------
`include "pressure_temperature_compensation_macros.svh"

module pressure_temperature_compensation (
  input logic       clk,
  input logic       rst_n,
  ptc_in_if.sink    in_ch,
  ptc_out_if.source out_ch,
  ptc_cfg_if.sink   cfg_ch
);
  import ptc_pkg::*;

  ptc_coef_t coef;
  ptc_ctrl_t ctrl;

  // Calibration registers and coefficient unpacking. The coefficients are
  // static while items flow, so each stage that uses them reads them directly.
  ptc_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_valid_i (cfg_ch.valid),
    .wr_ready_o (cfg_ch.ready),
    .wr_index_i (cfg_ch.index),
    .wr_data_i  (cfg_ch.data),
    .coef_o     (coef)
  );

  // Valid bits travel alongside the data; each stage's enable is also its
  // load strobe in the datapath.
  ptc_pipe_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .ctrl_o      (ctrl)
  );

  // Pressure is evaluated in nested form, each level one multiply by a raw
  // code followed by an add of a scaled coefficient. Wide multiplies are
  // split into narrow partial products and summed in the following stage.
  ptc_datapath u_dp (
    .clk                       (clk),
    .ctrl_i                    (ctrl),
    .coef_i                    (coef),
    .raw_pressure_code_i       (in_ch.raw_pressure_code),
    .raw_temperature_code_i    (in_ch.raw_temperature_code),
    .status_o                  (out_ch.status),
    .pressure_pascal_o         (out_ch.pressure_pascal),
    .temperature_millidegree_o (out_ch.temperature_millidegree)
  );

  // An accepted item always lands in the first stage.
  `PTC_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_ch.valid && in_ch.ready, ctrl.vld[0])
  // With every stage occupied and the output stalled, no item may be taken.
  `PTC_ASSERT_IMP(a_full_blocks, clk, rst_n, (&ctrl.vld) && !out_ch.ready, !in_ch.ready)
  // A result flagged as uncalibrated carries zero values.
  `PTC_ASSERT_IMP(a_status_zero, clk, rst_n, out_ch.valid && out_ch.status,
                  out_ch.pressure_pascal == '0 && out_ch.temperature_millidegree == '0)

endmodule

@@ design/ptc_cfg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Calibration registers
// Holds the calibration words and unpacks the nine signed coefficients.
// ---------------------------------------------------------------------------
module ptc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_valid_i,
  output logic                          wr_ready_o,
  input  logic [ptc_pkg::CFG_IDX_W-1:0] wr_index_i,
  input  logic [ptc_pkg::CFG_DAT_W-1:0] wr_data_i,
  output ptc_pkg::ptc_coef_t            coef_o
);
  import ptc_pkg::*;

  logic [63:0] cal_a_r;
  logic [63:0] cal_b_r;
  logic [15:0] cal_c_r;
  logic        loaded_r;

  assign wr_ready_o = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r  <= '0;
      cal_b_r  <= '0;
      cal_c_r  <= '0;
      loaded_r <= 1'b0;
    end else if (wr_valid_i) begin
      case (wr_index_i)
        CFG_CAL_A:      cal_a_r  <= wr_data_i;
        CFG_CAL_B:      cal_b_r  <= wr_data_i;
        CFG_CAL_C:      cal_c_r  <= wr_data_i[15:0];
        CFG_CAL_LOADED: loaded_r <= wr_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Byte 0 sits in the top byte of the first word, so each field is a plain slice.
  always_comb begin
    coef_o.loaded = loaded_r;
    coef_o.c0     = $signed(cal_a_r[63:52]);
    coef_o.c1     = $signed(cal_a_r[51:40]);
    coef_o.c00    = $signed(cal_a_r[39:20]);
    coef_o.c10    = $signed(cal_a_r[19:0]);
    coef_o.c01    = $signed(cal_b_r[63:48]);
    coef_o.c11    = $signed(cal_b_r[47:32]);
    coef_o.c20    = $signed(cal_b_r[31:16]);
    coef_o.c21    = $signed(cal_b_r[15:0]);
    coef_o.c30    = $signed(cal_c_r);
  end

endmodule

@@ design/ptc_pipe_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipeline control
// Per-stage valid bits and enables; a stage advances when it is empty or
// when the stage after it advances, so bubbles are squeezed out on a stall.
// ---------------------------------------------------------------------------
module ptc_pipe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptc_pkg::ptc_ctrl_t ctrl_o
);
  import ptc_pkg::*;

  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic [STAGES-1:0] en;

  assign en[STAGES-1] = !vld_r[STAGES-1] || out_ready_i;

  for (genvar g = 0; g < STAGES - 1; g++) begin : g_en
    assign en[g] = !vld_r[g] || en[g+1];
  end

  assign vld_nxt[0] = en[0] ? in_valid_i : vld_r[0];

  for (genvar g = 1; g < STAGES; g++) begin : g_vld
    assign vld_nxt[g] = en[g] ? vld_r[g-1] : vld_r[g];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_r[STAGES-1];
  assign ctrl_o.en   = en;
  assign ctrl_o.vld  = vld_r;

endmodule

@@ design/ptc_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Compensation datapath
// Nine register stages of nested polynomial evaluation in exact fixed point.
// ---------------------------------------------------------------------------
module ptc_datapath (
  input  logic                               clk,
  input  ptc_pkg::ptc_ctrl_t                 ctrl_i,
  input  ptc_pkg::ptc_coef_t                 coef_i,
  input  logic [ptc_pkg::RAW_W-1:0]          raw_pressure_code_i,
  input  logic [ptc_pkg::RAW_W-1:0]          raw_temperature_code_i,
  output logic                               status_o,
  output logic signed [ptc_pkg::PRESS_W-1:0] pressure_pascal_o,
  output logic signed [ptc_pkg::TEMP_W-1:0]  temperature_millidegree_o
);
  import ptc_pkg::*;

  localparam int SH1    = SCALE_SHIFT;
  localparam int SH2    = 2 * SCALE_SHIFT;
  localparam int SH3    = 3 * SCALE_SHIFT;
  localparam int M1_W   = 40;   // raw code times 16-bit coefficient
  localparam int X1_W   = 42;   // first nesting level
  localparam int H1_W   = X1_W / 2;
  localparam int PP1_W  = 46;
  localparam int X2_W   = 66;   // second nesting level
  localparam int H2_W   = X2_W / 3;
  localparam int PP2_W  = 47;
  localparam int ACC_W  = 90;
  localparam int MT_W   = 36;
  localparam int TS_W   = 37;
  localparam int TK_W   = 48;

  // Stage 0: raw codes
  logic signed [RAW_W-1:0] p0_r, t0_r;
  // Stage 1: innermost products
  logic signed [RAW_W-1:0] p1_r, t1_r;
  logic signed [M1_W-1:0]  m30_r, m21_r, m30_nxt, m21_nxt;
  logic signed [MT_W-1:0]  mt_r, mt_nxt;
  // Stage 2: add scaled coefficients
  logic signed [RAW_W-1:0] p2_r, t2_r;
  logic signed [X1_W-1:0]  x1_r, y1_r, x1_nxt, y1_nxt;
  logic signed [TS_W-1:0]  ts_r, ts_nxt;
  // Stage 3: split products with the pressure code
  logic signed [RAW_W-1:0] p3_r, t3_r;
  logic signed [PP1_W-1:0] xl_r, xh_r, yl_r, yh_r;
  logic signed [PP1_W-1:0] xl_nxt, xh_nxt, yl_nxt, yh_nxt;
  logic signed [TK_W-1:0]  tk_r, tk_nxt;
  // Stage 4: reassemble and add scaled coefficients
  logic signed [RAW_W-1:0] p4_r, t4_r;
  logic signed [X2_W-1:0]  x2_r, y2_r, x2_nxt, y2_nxt;
  logic signed [TEMP_W-1:0] tq4_r, tq_nxt;
  logic signed [TK_W-1:0]  tk_sh;
  logic                    tk_rnd;
  logic signed [TK_W-1:0]  tk_sum;
  // Stage 5: outermost split products
  logic signed [PP2_W-1:0] px0_r, px1_r, px2_r, ty0_r, ty1_r, ty2_r;
  logic signed [PP2_W-1:0] px0_nxt, px1_nxt, px2_nxt, ty0_nxt, ty1_nxt, ty2_nxt;
  logic signed [TEMP_W-1:0] tq5_r;
  // Stage 6: partial sums
  logic signed [ACC_W-1:0] sx_r, sy_r, sx_nxt, sy_nxt;
  logic signed [TEMP_W-1:0] tq6_r;
  // Stage 7: pressure times two to the 57
  logic signed [ACC_W-1:0] n_r, n_nxt;
  logic signed [TEMP_W-1:0] tq7_r;
  // Stage 8: output register
  logic signed [ACC_W-1:0] n_sh, n_sum;
  logic                    n_rnd;
  logic                    status_r, status_nxt;
  logic signed [PRESS_W-1:0] press_r, press_nxt;
  logic signed [TEMP_W-1:0]  temp_r, temp_nxt;

  always_comb begin
    m30_nxt = M1_W'(p0_r) * M1_W'(coef_i.c30);
    m21_nxt = M1_W'(p0_r) * M1_W'(coef_i.c21);
    mt_nxt  = MT_W'(t0_r) * MT_W'(coef_i.c1);

    x1_nxt = X1_W'(m30_r) + (X1_W'(coef_i.c20) <<< SH1);
    y1_nxt = X1_W'(m21_r) + (X1_W'(coef_i.c11) <<< SH1);
    ts_nxt = TS_W'(mt_r) + (TS_W'(coef_i.c0) <<< (SH1 - 1));

    xl_nxt = PP1_W'(p2_r) * PP1_W'($signed({1'b0, x1_r[H1_W-1:0]}));
    xh_nxt = PP1_W'(p2_r) * PP1_W'($signed(x1_r[X1_W-1:H1_W]));
    yl_nxt = PP1_W'(p2_r) * PP1_W'($signed({1'b0, y1_r[H1_W-1:0]}));
    yh_nxt = PP1_W'(p2_r) * PP1_W'($signed(y1_r[X1_W-1:H1_W]));
    tk_nxt = TK_W'(ts_r) * TK_W'(MILLI_PER_DEG);

    x2_nxt = (X2_W'(xh_r) <<< H1_W) + X2_W'(xl_r) + (X2_W'(coef_i.c10) <<< SH2);
    y2_nxt = (X2_W'(yh_r) <<< H1_W) + X2_W'(yl_r) + (X2_W'(coef_i.c01) <<< SH2);

    // Truncation toward zero: a negative value with a fraction moves up by one.
    tk_sh  = tk_r >>> SH1;
    tk_rnd = tk_r[TK_W-1] && (|tk_r[SH1-1:0]);
    tk_sum = tk_sh + $signed({{(TK_W-1){1'b0}}, tk_rnd});
    tq_nxt = $signed(tk_sum[TEMP_W-1:0]);

    px0_nxt = PP2_W'(p4_r) * PP2_W'($signed({1'b0, x2_r[H2_W-1:0]}));
    px1_nxt = PP2_W'(p4_r) * PP2_W'($signed({1'b0, x2_r[2*H2_W-1:H2_W]}));
    px2_nxt = PP2_W'(p4_r) * PP2_W'($signed(x2_r[X2_W-1:2*H2_W]));
    ty0_nxt = PP2_W'(t4_r) * PP2_W'($signed({1'b0, y2_r[H2_W-1:0]}));
    ty1_nxt = PP2_W'(t4_r) * PP2_W'($signed({1'b0, y2_r[2*H2_W-1:H2_W]}));
    ty2_nxt = PP2_W'(t4_r) * PP2_W'($signed(y2_r[X2_W-1:2*H2_W]));

    sx_nxt = ACC_W'(px0_r) + (ACC_W'(px1_r) <<< H2_W) + (ACC_W'(px2_r) <<< (2 * H2_W));
    sy_nxt = ACC_W'(ty0_r) + (ACC_W'(ty1_r) <<< H2_W) + (ACC_W'(ty2_r) <<< (2 * H2_W));

    n_nxt = sx_r + sy_r + (ACC_W'(coef_i.c00) <<< SH3);

    n_sh  = n_r >>> SH3;
    n_rnd = n_r[ACC_W-1] && (|n_r[SH3-1:0]);
    n_sum = n_sh + $signed({{(ACC_W-1){1'b0}}, n_rnd});

    status_nxt = !coef_i.loaded;
    press_nxt  = coef_i.loaded ? $signed(n_sum[PRESS_W-1:0]) : '0;
    temp_nxt   = coef_i.loaded ? tq7_r : '0;
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.en[0]) begin
      p0_r <= $signed(raw_pressure_code_i);
      t0_r <= $signed(raw_temperature_code_i);
    end
    if (ctrl_i.en[1]) begin
      p1_r  <= p0_r;
      t1_r  <= t0_r;
      m30_r <= m30_nxt;
      m21_r <= m21_nxt;
      mt_r  <= mt_nxt;
    end
    if (ctrl_i.en[2]) begin
      p2_r <= p1_r;
      t2_r <= t1_r;
      x1_r <= x1_nxt;
      y1_r <= y1_nxt;
      ts_r <= ts_nxt;
    end
    if (ctrl_i.en[3]) begin
      p3_r <= p2_r;
      t3_r <= t2_r;
      xl_r <= xl_nxt;
      xh_r <= xh_nxt;
      yl_r <= yl_nxt;
      yh_r <= yh_nxt;
      tk_r <= tk_nxt;
    end
    if (ctrl_i.en[4]) begin
      p4_r  <= p3_r;
      t4_r  <= t3_r;
      x2_r  <= x2_nxt;
      y2_r  <= y2_nxt;
      tq4_r <= tq_nxt;
    end
    if (ctrl_i.en[5]) begin
      px0_r <= px0_nxt;
      px1_r <= px1_nxt;
      px2_r <= px2_nxt;
      ty0_r <= ty0_nxt;
      ty1_r <= ty1_nxt;
      ty2_r <= ty2_nxt;
      tq5_r <= tq4_r;
    end
    if (ctrl_i.en[6]) begin
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      tq6_r <= tq5_r;
    end
    if (ctrl_i.en[7]) begin
      n_r   <= n_nxt;
      tq7_r <= tq6_r;
    end
    if (ctrl_i.en[8]) begin
      status_r <= status_nxt;
      press_r  <= press_nxt;
      temp_r   <= temp_nxt;
    end
  end

  assign status_o                  = status_r;
  assign pressure_pascal_o         = press_r;
  assign temperature_millidegree_o = temp_r;

endmodule
